[rtl/mme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg
// Shared command codes, register indexes and the control and status
// structs that pass between the matrix multiply controller and datapath.
// ----------------------------------------------------------------------------
package mme_pkg;

   // Input item kinds (carried on req_tuser)
   localparam logic [1:0] CMD_WRITE_A = 2'd0;
   localparam logic [1:0] CMD_WRITE_B = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [1:0] CSR_COLS_B    = 2'd2;

   localparam int IDX_W   = 3;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 32;
   localparam int SUM_W   = 35;
   localparam int DIM_W   = 4;

   typedef logic [IDX_W-1:0] idx_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic    wr_a;      // write store A at the request row/col
      logic    wr_b;      // write store B at the request row/col
      logic    rd_en;     // issue one MAC read pair
      logic    rd_first;  // first term of a dot product: restart the sum
      idx_type rd_row;    // row of A
      idx_type rd_k;      // column of A, row of B
      idx_type rd_col;    // column of B
      logic    out_load;  // load the finished sum into the result register
      idx_type out_row;
      idx_type out_col;
      logic    out_last;
   } mme_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;     // result register empty or being taken this cycle
   } mme_status_type;

endpackage

[rtl/mme_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_ctrl
// Controller: holds the dimension registers, takes input items, and walks
// the row, column and inner loops of a product, issuing MAC reads and
// result loads to the datapath.
// ----------------------------------------------------------------------------
module mme_ctrl
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  idx_type              req_row,
   input  idx_type              req_col,
   input  mme_status_type       status,
   output mme_cmd_type          cmd
);

   localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] inner_ff, inner_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   idx_type          rmax_ff, rmax_in;
   idx_type          kmax_ff, kmax_in;
   idx_type          cmax_ff, cmax_in;
   idx_type          i_ff, i_in;
   idx_type          j_ff, j_in;
   idx_type          k_ff, k_in;
   logic             drain_ff, drain_in;

   logic accept;
   logic in_range;
   logic is_last;

   // Largest index for a dimension register, clamped to [0, DIM_CAP-1]
   function automatic idx_type max_index(input logic [DIM_W-1:0] v);
      idx_type r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > DIM_CAP) begin
         r = IDX_W'(DIM_CAP - 1);
      end else begin
         r = IDX_W'(v - DIM_W'(1));
      end
      return r;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = (int'(req_row) < DIM_CAP) && (int'(req_col) < DIM_CAP);
   assign is_last   = (i_ff == rmax_ff) && (j_ff == cmax_ff);

   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS_A:    rows_in  = csr_wdata;
            CSR_INNER_DIM: inner_in = csr_wdata;
            CSR_COLS_B:    cols_in  = csr_wdata;
            default:       ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      rmax_in  = rmax_ff;
      kmax_in  = kmax_ff;
      cmax_in  = cmax_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      drain_in = drain_ff;

      cmd          = '0;
      cmd.rd_row   = i_ff;
      cmd.rd_k     = k_ff;
      cmd.rd_col   = j_ff;
      cmd.rd_first = (k_ff == '0);
      cmd.out_row  = i_ff;
      cmd.out_col  = j_ff;
      cmd.out_last = is_last;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_WRITE_A: cmd.wr_a = in_range;
                  CMD_WRITE_B: cmd.wr_b = in_range;
                  CMD_COMPUTE: begin
                     rmax_in  = max_index(rows_ff);
                     kmax_in  = max_index(inner_ff);
                     cmax_in  = max_index(cols_ff);
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     state_in = ST_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.rd_en = 1'b1;
            if (k_ff == kmax_ff) begin
               k_in     = '0;
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to reach the accumulator
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  if (j_ff == cmax_ff) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= DIM_W'(8);
         inner_ff <= DIM_W'(8);
         cols_ff  <= DIM_W'(8);
         rmax_ff  <= '0;
         kmax_ff  <= '0;
         cmax_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
         rmax_ff  <= rmax_in;
         kmax_ff  <= kmax_in;
         cmax_ff  <= cmax_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         drain_ff <= drain_in;
      end
   end

endmodule

[rtl/mme_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_dp
// Datapath: the two element stores, a registered multiply and a 35-bit
// accumulator, and the result register that feeds the output channel.
// ----------------------------------------------------------------------------
module mme_dp
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mme_cmd_type          cmd,
   output mme_status_type       status,
   input  idx_type              wr_row,
   input  idx_type              wr_col,
   input  logic [ELEM_W-1:0]    wr_value,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output idx_type              rsp_row,
   output idx_type              rsp_col,
   output logic [SUM_W-1:0]     rsp_value,
   output logic                 rsp_last
);

   localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
   localparam int DEPTH   = DIM_CAP * DIM_CAP;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ELEM_W-1:0] mem_a [DEPTH];
   logic [ELEM_W-1:0] mem_b [DEPTH];

   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

   logic [ELEM_W-1:0] ra_ff, rb_ff;
   logic              v1_ff, first1_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              v2_ff, first2_ff;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  prod_ext;

   logic              out_valid_ff, out_valid_in;
   idx_type           out_row_ff, out_col_ff;
   logic [SUM_W-1:0]  out_value_ff;
   logic              out_last_ff;

   assign wr_addr   = ADDR_W'(32'(wr_row) * DIM_CAP + 32'(wr_col));
   assign rd_addr_a = ADDR_W'(32'(cmd.rd_row) * DIM_CAP + 32'(cmd.rd_k));
   assign rd_addr_b = ADDR_W'(32'(cmd.rd_k) * DIM_CAP + 32'(cmd.rd_col));

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a[wr_addr] <= wr_value;
      end
      if (cmd.rd_en) begin
         ra_ff <= mem_a[rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b) begin
         mem_b[wr_addr] <= wr_value;
      end
      if (cmd.rd_en) begin
         rb_ff <= mem_b[rd_addr_b];
      end
   end

   // Q8.8 x Q8.8 gives exact Q16.16
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'($signed(ra_ff) * $signed(rb_ff));
      first1_ff <= cmd.rd_first;
      first2_ff <= first1_ff;
   end

   assign prod_ext = {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      acc_in = acc_ff;
      if (v2_ff) begin
         acc_in = first2_ff ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign status.out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_row_ff   <= cmd.out_row;
         out_col_ff   <= cmd.out_col;
         out_value_ff <= acc_ff;
         out_last_ff  <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.rd_en;
         v2_ff        <= v1_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_row    = out_row_ff;
   assign rsp_col    = out_col_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_last   = out_last_ff;

endmodule

[rtl/matrix_multiply_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Dense Q8.8 matrix multiply with element loads and a compute command.
// ----------------------------------------------------------------------------
// Load items (write A, write B) are accepted back to back. A compute item
// holds the input side until its last result is loaded, and longer while
// the result side stalls: one multiply-accumulate unit fed by a single read
// port on each store does one inner term per cycle, and each result then
// waits for the read, multiply and accumulate stages to drain. Results come
// out in row-major order with tlast on the final one. Dimensions are clamped
// to 1..min(MAX_DIM, 8); writes outside that range and unused commands are
// dropped. Store entries are not cleared by reset and must be written before
// a compute reads them.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [3:0]   csr_wdata,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // row_index[2:0], col_index[5:3], elem_value[21:6]
   input  logic [1:0]   req_tuser,   // cmd[1:0]
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // out_row[2:0], out_col[5:3], out_value[40:6]
   output logic         rsp_tlast    // last
);

   mme_cmd_type       cmd;
   mme_status_type    status;
   idx_type           req_row, req_col;
   logic [ELEM_W-1:0] req_value;
   idx_type           rsp_row, rsp_col;
   logic [SUM_W-1:0]  rsp_value;

   assign req_row   = req_tdata[2:0];
   assign req_col   = req_tdata[5:3];
   assign req_value = req_tdata[21:6];

   mme_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_row   (req_row),
      .req_col   (req_col),
      .status    (status),
      .cmd       (cmd)
   );

   mme_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .wr_row     (req_row),
      .wr_col     (req_col),
      .wr_value   (req_value),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, rsp_value, rsp_col, rsp_row};

endmodule

[rtl/mme_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks for the matrix multiply engine, bound to the top level.
// ----------------------------------------------------------------------------
module mme_checker
   import mme_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [47:0]  rsp_tdata,
   input logic         rsp_tlast
);

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A compute item closes the input side while the product runs
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_COMPUTE |=> !req_tready)
      else $error("input taken during a compute");

   // No result can appear while the block is idle and none was pending
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tready && !rsp_tvalid && !(req_tvalid && req_tuser == CMD_COMPUTE)
         |=> !rsp_tvalid)
      else $error("result without a compute");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);
